// ===== sv/twhsm_pkg.sv =====
// Shared types, phase codes and constant tables for the two-wire humidity sensor master.
// No dependencies; imported by twhsm_seq, two_wire_humidity_sensor_master and the testbench files.
package twhsm_pkg;

  // Command selectors carried by a start beat.
  localparam logic [2:0] CMD_CONN_RESET   = 3'd0;
  localparam logic [2:0] CMD_SOFT_RESET   = 3'd1;
  localparam logic [2:0] CMD_MEASURE_TEMP = 3'd2;
  localparam logic [2:0] CMD_MEASURE_HUM  = 3'd3;
  localparam logic [2:0] CMD_READ_STATUS  = 3'd4;
  localparam logic [2:0] CMD_WRITE_STATUS = 3'd5;

  // Command bytes sent on the bus.
  localparam logic [7:0] CODE_SOFT_RESET   = 8'h1e;
  localparam logic [7:0] CODE_MEASURE_TEMP = 8'h03;
  localparam logic [7:0] CODE_MEASURE_HUM  = 8'h05;
  localparam logic [7:0] CODE_READ_STATUS  = 8'h07;
  localparam logic [7:0] CODE_WRITE_STATUS = 8'h06;

  localparam logic [7:0] TPU_RESET = 8'd8;

  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    PH_CRH  = 20'h00002,
    PH_CRL  = 20'h00004,
    PH_TSA  = 20'h00008,
    PH_TSB  = 20'h00010,
    PH_TSC  = 20'h00020,
    PH_TSD  = 20'h00040,
    PH_TSE  = 20'h00080,
    PH_TSF  = 20'h00100,
    PH_WRL  = 20'h00200,
    PH_WRH  = 20'h00400,
    PH_WAL  = 20'h00800,
    PH_WAH1 = 20'h01000,
    PH_WAH2 = 20'h02000,
    PH_WAIT = 20'h04000,
    PH_RDL  = 20'h08000,
    PH_RDH1 = 20'h10000,
    PH_RDH2 = 20'h20000,
    PH_RAL  = 20'h40000,
    PH_RAH  = 20'h80000
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [2:0] command;
    logic [7:0] status_value;
    logic       data_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_level;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  ack_errors;
    logic [15:0] measured_raw;
    logic        measured_kind;
    logic [7:0]  checksum_byte;
    logic [7:0]  status_read;
  } result_t;

  // Phase length in microseconds.
  function automatic logic [2:0] phase_len(input phase_e p);
    logic [2:0] len;
    case (p)
      PH_CRH, PH_CRL, PH_WRL, PH_WAL, PH_RDL, PH_RAL: len = 3'd1;
      PH_TSA, PH_TSB, PH_TSC, PH_TSE, PH_TSF:         len = 3'd2;
      PH_WAH1, PH_WAH2, PH_RDH1, PH_RDH2:             len = 3'd2;
      PH_TSD, PH_WRH, PH_RAH:                         len = 3'd5;
      default:                                        len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] cmd_code(input logic [2:0] cmd);
    logic [7:0] code;
    case (cmd)
      CMD_SOFT_RESET:   code = CODE_SOFT_RESET;
      CMD_MEASURE_TEMP: code = CODE_MEASURE_TEMP;
      CMD_MEASURE_HUM:  code = CODE_MEASURE_HUM;
      CMD_READ_STATUS:  code = CODE_READ_STATUS;
      CMD_WRITE_STATUS: code = CODE_WRITE_STATUS;
      default:          code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/two_wire_humidity_sensor_master.sv =====
// Top level of the two-wire humidity sensor master: stream ports and the result register.
// Depends on twhsm_pkg and twhsm_seq.
// A result beat comes from the result register, loaded when its input beat is accepted.
// Throughput: one input beat per cycle unless a result stalls; only the sequencer loops.
// Reset (rst_ni low, asynchronous): bus idle, all stores zero, ticks per microsecond 8.
module two_wire_humidity_sensor_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low bit up: command[2:0], status_value[10:3], data_in[11], zero[15:12]
  input  logic [15:0] s_axis_tdata,
  // tuser: action[0] (0 = tick, 1 = start command)
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: clock_level[0], data_level[1], data_drive[2], busy_res[3],
  // done_res[4], ack_errors[6:5], measured_raw[22:7], checksum_byte[30:23],
  // status_read[38:31], zero[39]
  output logic [39:0] m_axis_tdata,
  // tuser: measured_kind[0] (0 = temperature, 1 = humidity)
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import twhsm_pkg::*;

  in_item_t item;
  result_t  result;
  result_t  out_q;
  logic     out_valid_q, out_valid_d;
  logic     in_accept;

  // The result register holds one beat; a new input beat is taken whenever that beat
  // is leaving or the register is empty, so a tick stream can run at full rate.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign item.action       = s_axis_tuser[0];
  assign item.command      = s_axis_tdata[2:0];
  assign item.status_value = s_axis_tdata[10:3];
  assign item.data_in      = s_axis_tdata[11];

  twhsm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_accept),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.status_read, out_q.checksum_byte, out_q.measured_raw,
                          out_q.ack_errors, out_q.done_res, out_q.busy_res,
                          out_q.data_drive, out_q.data_level, out_q.clock_level};
  assign m_axis_tuser  = out_q.measured_kind;

  // A finishing beat always reports the sequencer back at rest.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done reported while still busy");

  // A released data line always reads back as high.
  a_release_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("released data line not reported high");

  // When idle the bus is parked: clock low and data released.
  a_idle_parked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> !m_axis_tdata[0] && !m_axis_tdata[2])
    else $error("bus not parked while idle");

  // A stalled result beat must block the input side.
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

endmodule

// ===== sv/twhsm_seq.sv =====
// Bus sequencer: phase state, microsecond prescaler, shift and counters, result stores.
// Depends on twhsm_pkg; the result it presents reflects the state after the current beat.
module twhsm_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  twhsm_pkg::in_item_t item_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output twhsm_pkg::result_t result_o
);
  import twhsm_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [3:0]  bit_q, bit_d;
  logic [1:0]  byte_q, byte_d;
  logic [2:0]  pd_q, pd_d;
  logic [7:0]  presc_q, presc_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  err_q, err_d;
  logic [15:0] reading_q [2];
  logic [15:0] reading_d [2];
  logic [7:0]  csum_q, csum_d;
  logic [7:0]  status_q, status_d;
  logic        kind_q, kind_d;
  logic [7:0]  tpu_q;

  logic        done;
  logic [8:0]  presc_inc;
  logic [2:0]  pd_inc;
  logic [3:0]  bit_inc;
  logic        last_read_q;
  logic        last_read_d;
  logic        wbit_d;
  logic [7:0]  wbyte_d;

  assign presc_inc   = {1'b0, presc_q} + 9'd1;
  assign pd_inc      = pd_q + 3'd1;
  assign bit_inc     = bit_q + 4'd1;
  assign last_read_q = (cmd_q == CMD_READ_STATUS) ? (byte_q == 2'd1) : (byte_q == 2'd2);

  always_comb begin
    phase_d      = phase_q;
    cmd_d        = cmd_q;
    bit_d        = bit_q;
    byte_d       = byte_q;
    pd_d         = pd_q;
    presc_d      = presc_q;
    shift_d      = shift_q;
    err_d        = err_q;
    reading_d[0] = reading_q[0];
    reading_d[1] = reading_q[1];
    csum_d       = csum_q;
    status_d     = status_q;
    kind_d       = kind_q;
    done         = 1'b0;
    if (step_i) begin
      if (item_i.action) begin
        if (phase_q == PH_IDLE && item_i.command <= CMD_WRITE_STATUS) begin
          cmd_d   = item_i.command;
          shift_d = item_i.status_value;
          err_d   = 2'd0;
          bit_d   = 4'd0;
          byte_d  = 2'd0;
          pd_d    = 3'd0;
          presc_d = 8'd0;
          phase_d = (item_i.command <= CMD_SOFT_RESET) ? PH_CRH : PH_TSA;
        end
      end else if (phase_q == PH_WAIT) begin
        if (!item_i.data_in) begin
          byte_d  = 2'd0;
          bit_d   = 4'd0;
          pd_d    = 3'd0;
          presc_d = 8'd0;
          phase_d = PH_RDL;
        end
      end else if (phase_q != PH_IDLE) begin
        if (presc_inc >= {1'b0, tpu_q}) begin
          presc_d = 8'd0;
          pd_d    = pd_inc;
          if (pd_inc >= phase_len(phase_q)) begin
            pd_d = 3'd0;
            case (phase_q)
              PH_CRH: phase_d = PH_CRL;
              PH_CRL: begin
                if (bit_inc >= 4'd9) begin
                  bit_d   = 4'd0;
                  phase_d = PH_TSA;
                end else begin
                  bit_d   = bit_inc;
                  phase_d = PH_CRH;
                end
              end
              PH_TSA: phase_d = PH_TSB;
              PH_TSB: phase_d = PH_TSC;
              PH_TSC: phase_d = PH_TSD;
              PH_TSD: phase_d = PH_TSE;
              PH_TSE: phase_d = PH_TSF;
              PH_TSF: begin
                if (cmd_q == CMD_CONN_RESET) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bit_d   = 4'd0;
                  byte_d  = 2'd0;
                  phase_d = PH_WRL;
                end
              end
              PH_WRL: phase_d = PH_WRH;
              PH_WRH: begin
                if (bit_inc >= 4'd8) begin
                  bit_d   = 4'd0;
                  phase_d = PH_WAL;
                end else begin
                  bit_d   = bit_inc;
                  phase_d = PH_WRL;
                end
              end
              PH_WAL: phase_d = PH_WAH1;
              PH_WAH1: begin
                // A high data line at the sample point is a missing acknowledge.
                if (item_i.data_in && err_q != 2'd3) begin
                  err_d = err_q + 2'd1;
                end
                phase_d = PH_WAH2;
              end
              PH_WAH2: begin
                if (cmd_q == CMD_WRITE_STATUS && byte_q == 2'd0) begin
                  byte_d  = 2'd1;
                  bit_d   = 4'd0;
                  phase_d = PH_WRL;
                end else if (cmd_q == CMD_MEASURE_TEMP || cmd_q == CMD_MEASURE_HUM) begin
                  phase_d = PH_WAIT;
                end else if (cmd_q == CMD_READ_STATUS) begin
                  byte_d  = 2'd0;
                  bit_d   = 4'd0;
                  phase_d = PH_RDL;
                end else begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
              end
              PH_RDL: phase_d = PH_RDH1;
              PH_RDH1: begin
                shift_d = {shift_q[6:0], item_i.data_in};
                phase_d = PH_RDH2;
              end
              PH_RDH2: begin
                if (bit_inc >= 4'd8) begin
                  bit_d   = 4'd0;
                  phase_d = PH_RAL;
                  if (cmd_q == CMD_READ_STATUS) begin
                    if (byte_q == 2'd0) begin
                      status_d = shift_q;
                    end else begin
                      csum_d = shift_q;
                    end
                  end else if (byte_q == 2'd0) begin
                    kind_d = (cmd_q == CMD_MEASURE_HUM);
                    reading_d[cmd_q == CMD_MEASURE_HUM] = {shift_q, 8'h00};
                  end else if (byte_q == 2'd1) begin
                    reading_d[kind_q] = reading_q[kind_q] | {8'h00, shift_q};
                  end else begin
                    csum_d = shift_q;
                  end
                end else begin
                  bit_d   = bit_inc;
                  phase_d = PH_RDL;
                end
              end
              PH_RAL: phase_d = PH_RAH;
              PH_RAH: begin
                if (last_read_q) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  byte_d  = byte_q + 2'd1;
                  phase_d = PH_RDL;
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end else begin
          presc_d = presc_inc[7:0];
        end
      end
    end
  end

  // Bus drive is decoded from the state this beat leaves behind.
  assign last_read_d = (cmd_d == CMD_READ_STATUS) ? (byte_d == 2'd1) : (byte_d == 2'd2);
  assign wbyte_d     = (byte_d == 2'd0) ? cmd_code(cmd_d) : shift_d;
  assign wbit_d      = wbyte_d[3'd7 - bit_d[2:0]];

  always_comb begin
    result_o.clock_level = 1'b0;
    result_o.data_level  = 1'b1;
    result_o.data_drive  = 1'b0;
    case (phase_d)
      PH_CRH, PH_TSB, PH_TSF: begin
        result_o.clock_level = 1'b1;
        result_o.data_drive  = 1'b1;
      end
      PH_CRL, PH_TSA: result_o.data_drive = 1'b1;
      PH_TSC, PH_TSE: begin
        result_o.clock_level = 1'b1;
        result_o.data_level  = 1'b0;
        result_o.data_drive  = 1'b1;
      end
      PH_TSD: begin
        result_o.data_level = 1'b0;
        result_o.data_drive = 1'b1;
      end
      PH_WRL: begin
        result_o.data_level = wbit_d;
        result_o.data_drive = 1'b1;
      end
      PH_WRH: begin
        result_o.clock_level = 1'b1;
        result_o.data_level  = wbit_d;
        result_o.data_drive  = 1'b1;
      end
      PH_WAH1, PH_WAH2, PH_RDH1, PH_RDH2: result_o.clock_level = 1'b1;
      PH_RAL: begin
        result_o.data_level = last_read_d;
        result_o.data_drive = 1'b1;
      end
      PH_RAH: begin
        result_o.clock_level = 1'b1;
        result_o.data_level  = last_read_d;
        result_o.data_drive  = 1'b1;
      end
      default: ;
    endcase
    result_o.busy_res      = (phase_d != PH_IDLE);
    result_o.done_res      = done;
    result_o.ack_errors    = err_d;
    result_o.measured_raw  = reading_d[kind_d];
    result_o.measured_kind = kind_d;
    result_o.checksum_byte = csum_d;
    result_o.status_read   = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cmd_q        <= 3'd0;
      bit_q        <= 4'd0;
      byte_q       <= 2'd0;
      pd_q         <= 3'd0;
      presc_q      <= 8'd0;
      shift_q      <= 8'd0;
      err_q        <= 2'd0;
      reading_q[0] <= 16'd0;
      reading_q[1] <= 16'd0;
      csum_q       <= 8'd0;
      status_q     <= 8'd0;
      kind_q       <= 1'b0;
      tpu_q        <= TPU_RESET;
    end else begin
      phase_q      <= phase_d;
      cmd_q        <= cmd_d;
      bit_q        <= bit_d;
      byte_q       <= byte_d;
      pd_q         <= pd_d;
      presc_q      <= presc_d;
      shift_q      <= shift_d;
      err_q        <= err_d;
      reading_q[0] <= reading_d[0];
      reading_q[1] <= reading_d[1];
      csum_q       <= csum_d;
      status_q     <= status_d;
      kind_q       <= kind_d;
      if (cfg_we_i) begin
        tpu_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== tb/sv/twhsm_bus_checker.sv =====
// Checker for the two-wire humidity sensor master: predicts every result beat and compares it.
// Depends on twhsm_pkg for the phase enum, command selectors, command bytes and result struct.
module twhsm_bus_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o
);
  import twhsm_pkg::*;

  // Predicted sequencer state.
  phase_e      phase_q;
  logic [2:0]  cmd_q;
  logic [3:0]  bit_q;
  logic [1:0]  byte_q;
  logic [2:0]  usec_q;
  logic [7:0]  presc_q;
  logic [7:0]  shift_q;
  logic [1:0]  nack_q;
  logic [15:0] reading_q [2];
  logic [7:0]  crc_q;
  logic [7:0]  status_q;
  logic [7:0]  tpu_q;
  logic        kind_q;
  logic        done_q;

  result_t bus_views_due [$];
  int      mismatch_count = 0;
  int      outstanding = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = outstanding;

  function automatic logic [2:0] usec_in(input phase_e p);
    logic [2:0] n;
    case (p)
      PH_CRH, PH_CRL, PH_WRL, PH_WAL, PH_RDL, PH_RAL: n = 3'd1;
      PH_TSD, PH_WRH, PH_RAH:                         n = 3'd5;
      PH_TSA, PH_TSB, PH_TSC, PH_TSE, PH_TSF,
      PH_WAH1, PH_WAH2, PH_RDH1, PH_RDH2:             n = 3'd2;
      default:                                        n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] opcode_of(input logic [2:0] c);
    logic [7:0] b;
    case (c)
      CMD_SOFT_RESET:   b = CODE_SOFT_RESET;
      CMD_MEASURE_TEMP: b = CODE_MEASURE_TEMP;
      CMD_MEASURE_HUM:  b = CODE_MEASURE_HUM;
      CMD_READ_STATUS:  b = CODE_READ_STATUS;
      CMD_WRITE_STATUS: b = CODE_WRITE_STATUS;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

  // Read status takes two bytes, the measurements three.
  function automatic logic last_read();
    return (cmd_q == CMD_READ_STATUS) ? (byte_q == 2'd1) : (byte_q == 2'd2);
  endfunction

  // First byte is the command code, the second the status value; MSB first.
  function automatic logic tx_bit();
    logic [7:0] b;
    b = (byte_q == 2'd0) ? opcode_of(cmd_q) : shift_q;
    return b[3'd7 - bit_q[2:0]];
  endfunction

  task automatic latch_read_byte();
    if (cmd_q == CMD_READ_STATUS) begin
      if (byte_q == 2'd0) status_q = shift_q;
      else crc_q = shift_q;
    end else if (byte_q == 2'd0) begin
      kind_q = (cmd_q == CMD_MEASURE_HUM);
      reading_q[kind_q] = {shift_q, 8'h00};
    end else if (byte_q == 2'd1) begin
      reading_q[kind_q] = reading_q[kind_q] | {8'h00, shift_q};
    end else begin
      crc_q = shift_q;
    end
  endtask

  task automatic close_phase(input logic din);
    case (phase_q)
      PH_CRH: phase_q = PH_CRL;
      PH_CRL: begin
        bit_q = bit_q + 4'd1;
        if (bit_q >= 4'd9) begin
          bit_q   = '0;
          phase_q = PH_TSA;
        end else phase_q = PH_CRH;
      end
      // The start phases follow one another; the codes are one-hot in order.
      PH_TSA, PH_TSB, PH_TSC, PH_TSD, PH_TSE: phase_q = phase_e'(phase_q << 1);
      PH_TSF: begin
        if (cmd_q == CMD_CONN_RESET) begin
          phase_q = PH_IDLE;
          done_q  = 1'b1;
        end else begin
          bit_q   = '0;
          byte_q  = '0;
          phase_q = PH_WRL;
        end
      end
      PH_WRL: phase_q = PH_WRH;
      PH_WRH: begin
        bit_q = bit_q + 4'd1;
        if (bit_q >= 4'd8) begin
          bit_q   = '0;
          phase_q = PH_WAL;
        end else phase_q = PH_WRL;
      end
      PH_WAL: phase_q = PH_WAH1;
      PH_WAH1: begin
        if (din && nack_q != 2'd3) nack_q = nack_q + 2'd1;
        phase_q = PH_WAH2;
      end
      PH_WAH2: begin
        if (cmd_q == CMD_WRITE_STATUS && byte_q == 2'd0) begin
          byte_q  = 2'd1;
          bit_q   = '0;
          phase_q = PH_WRL;
        end else if (cmd_q == CMD_MEASURE_TEMP || cmd_q == CMD_MEASURE_HUM) begin
          phase_q = PH_WAIT;
        end else if (cmd_q == CMD_READ_STATUS) begin
          byte_q  = '0;
          bit_q   = '0;
          phase_q = PH_RDL;
        end else begin
          phase_q = PH_IDLE;
          done_q  = 1'b1;
        end
      end
      PH_RDL: phase_q = PH_RDH1;
      PH_RDH1: begin
        shift_q = {shift_q[6:0], din};
        phase_q = PH_RDH2;
      end
      PH_RDH2: begin
        bit_q = bit_q + 4'd1;
        if (bit_q >= 4'd8) begin
          bit_q = '0;
          latch_read_byte();
          phase_q = PH_RAL;
        end else phase_q = PH_RDL;
      end
      PH_RAL: phase_q = PH_RAH;
      PH_RAH: begin
        if (last_read()) begin
          phase_q = PH_IDLE;
          done_q  = 1'b1;
        end else begin
          byte_q  = byte_q + 2'd1;
          phase_q = PH_RDL;
        end
      end
      default: phase_q = PH_IDLE;
    endcase
  endtask

  task automatic advance_sequencer(input logic start, input logic [2:0] cmd,
                                   input logic [7:0] sv, input logic din);
    logic [8:0] next;
    done_q = 1'b0;
    if (start) begin
      if (phase_q == PH_IDLE && cmd <= CMD_WRITE_STATUS) begin
        cmd_q   = cmd;
        shift_q = sv;
        nack_q  = '0;
        bit_q   = '0;
        byte_q  = '0;
        usec_q  = '0;
        presc_q = '0;
        phase_q = (cmd <= CMD_SOFT_RESET) ? PH_CRH : PH_TSA;
      end
    end else if (phase_q == PH_WAIT) begin
      // The sensor signals a finished measurement by pulling data low.
      if (!din) begin
        byte_q  = '0;
        bit_q   = '0;
        usec_q  = '0;
        presc_q = '0;
        phase_q = PH_RDL;
      end
    end else if (phase_q != PH_IDLE) begin
      next = {1'b0, presc_q} + 9'd1;
      if (next >= {1'b0, tpu_q}) begin
        presc_q = '0;
        usec_q  = usec_q + 3'd1;
        if (usec_q >= usec_in(phase_q)) begin
          usec_q = '0;
          close_phase(din);
        end
      end else begin
        presc_q = next[7:0];
      end
    end
  endtask

  function automatic result_t bus_snapshot();
    result_t r;
    r = '0;
    r.data_level = 1'b1;
    case (phase_q)
      PH_CRH, PH_TSB, PH_TSF: begin
        r.clock_level = 1'b1;
        r.data_drive  = 1'b1;
      end
      PH_CRL, PH_TSA: r.data_drive = 1'b1;
      PH_TSC, PH_TSE: begin
        r.clock_level = 1'b1;
        r.data_level  = 1'b0;
        r.data_drive  = 1'b1;
      end
      PH_TSD: begin
        r.data_level = 1'b0;
        r.data_drive = 1'b1;
      end
      PH_WRL, PH_WRH: begin
        r.clock_level = (phase_q == PH_WRH);
        r.data_level  = tx_bit();
        r.data_drive  = 1'b1;
      end
      PH_WAH1, PH_WAH2, PH_RDH1, PH_RDH2: r.clock_level = 1'b1;
      PH_RAL, PH_RAH: begin
        r.clock_level = (phase_q == PH_RAH);
        r.data_level  = last_read();
        r.data_drive  = 1'b1;
      end
      default: ;
    endcase
    r.busy_res      = (phase_q != PH_IDLE);
    r.done_res      = done_q;
    r.ack_errors    = nack_q;
    r.measured_raw  = reading_q[kind_q];
    r.measured_kind = kind_q;
    r.checksum_byte = crc_q;
    r.status_read   = status_q;
    return r;
  endfunction

  task automatic judge(input string field, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      phase_q      = PH_IDLE;
      cmd_q        = '0;
      bit_q        = '0;
      byte_q       = '0;
      usec_q       = '0;
      presc_q      = '0;
      shift_q      = '0;
      nack_q       = '0;
      reading_q[0] = '0;
      reading_q[1] = '0;
      crc_q        = '0;
      status_q     = '0;
      tpu_q        = TPU_RESET;
      kind_q       = 1'b0;
      done_q       = 1'b0;
      bus_views_due.delete();
    end else begin
      // Results are checked before the new input is predicted: a result beat
      // always belongs to an input accepted at an earlier edge.
      if (m_axis_tvalid && m_axis_tready) begin
        seen.clock_level   = m_axis_tdata[0];
        seen.data_level    = m_axis_tdata[1];
        seen.data_drive    = m_axis_tdata[2];
        seen.busy_res      = m_axis_tdata[3];
        seen.done_res      = m_axis_tdata[4];
        seen.ack_errors    = m_axis_tdata[6:5];
        seen.measured_raw  = m_axis_tdata[22:7];
        seen.checksum_byte = m_axis_tdata[30:23];
        seen.status_read   = m_axis_tdata[38:31];
        seen.measured_kind = m_axis_tuser[0];
        if (bus_views_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none actual %h",
                   $time, seen);
          mismatch_count++;
        end else begin
          want = bus_views_due.pop_front();
          judge("clock_level", 16'(want.clock_level), 16'(seen.clock_level));
          judge("data_level", 16'(want.data_level), 16'(seen.data_level));
          judge("data_drive", 16'(want.data_drive), 16'(seen.data_drive));
          judge("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
          judge("done_res", 16'(want.done_res), 16'(seen.done_res));
          judge("ack_errors", 16'(want.ack_errors), 16'(seen.ack_errors));
          judge("measured_raw", want.measured_raw, seen.measured_raw);
          judge("measured_kind", 16'(want.measured_kind), 16'(seen.measured_kind));
          judge("checksum_byte", 16'(want.checksum_byte), 16'(seen.checksum_byte));
          judge("status_read", 16'(want.status_read), 16'(seen.status_read));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_sequencer(s_axis_tuser[0], s_axis_tdata[2:0], s_axis_tdata[10:3],
                          s_axis_tdata[11]);
        bus_views_due.push_back(bus_snapshot());
      end
      if (cfg_we_i) tpu_q = cfg_wdata_i;
    end
    outstanding = bus_views_due.size();
  end

endmodule

// ===== tb/sv/two_wire_humidity_sensor_master_tb.sv =====
// Testbench top for the two-wire humidity sensor master: clock, reset, stimulus and verdict.
// Depends on twhsm_pkg, the block itself and twhsm_bus_checker, which predicts and compares.
module two_wire_humidity_sensor_master_tb;
  import twhsm_pkg::*;

  // Longest stretch without any accepted beat before the run is declared hung.
  // The deliberate receiver hold-off is the longest correct one by far.
  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 300;
  // Input beats in the whole run, directed part included.
  localparam int TargetBeats = 1250;

  // Selectors beyond the last command; a start carrying one is ignored.
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  // Positions of the status bits in the result tdata.
  localparam int BusyBit = 3;
  localparam int DoneBit = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  int   mismatches;
  int   pending;
  int   done_seen = 0;
  logic busy_seen = 1'b0;
  int   hold_go = 0;
  int   hold_done = 0;
  logic calm = 1'b0;
  int   beats_counted = 0;
  int   tpu_now = 8;
  int   quiet_cycles = 0;

  two_wire_humidity_sensor_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  twhsm_bus_checker u_bus_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver drops tready at random, except during a calm stretch. When the
  // stimulus asks for it, it holds off completely for a long stretch so that the
  // result register stays full and the block has to stall its input.
  initial begin : receiver
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go != hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = hold_go;
      end else begin
        m_axis_tready = calm || ($urandom_range(99) >= 24);
      end
    end
  end

  // The stimulus follows the block through the result beats: it counts finished
  // sequences and remembers whether the latest result said busy.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tdata[DoneBit]) done_seen <= done_seen + 1;
      busy_seen <= m_axis_tdata[BusyBit];
    end
  end

  // Watchdog: any accepted beat on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one input beat, after a random number of idle cycles, and returns once
  // it is accepted. With may_poke set, the beat may instead become a start beat with
  // a random selector; that is only done when the block is known to be busy (the
  // latest result said so and nothing is in flight), so the block must ignore it.
  task automatic offer(input logic start, input logic [2:0] cmd, input logic [7:0] sv,
                       input logic din, input logic may_poke, output logic poked);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 24) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    poked = may_poke && pending == 0 && busy_seen && ($urandom_range(99) < 10);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = start | poked;
    s_axis_tdata  = {4'd0, din, sv, poked ? 3'($urandom_range(7)) : cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every result has come back and the block is idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0 || busy_seen) @(negedge clk_i);
  endtask

  task automatic write_tpu(input int value);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = 8'(value);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tpu_now     = (value == 0) ? 1 : value;
  endtask

  // Runs one command sequence: a start beat, then tick beats until a result beat
  // reports the sequence done. The sampled data line is high for the first
  // high_ticks ticks (a sensor that does not answer) and afterwards is high with
  // probability p_one percent. Ticks also carry random command and status bits,
  // which the block must not look at.
  task automatic run_sequence(input logic [2:0] cmd, input logic [7:0] sv, input int p_one,
                              input int high_ticks, input logic noise);
    int   first_done;
    int   ticks;
    int   cap;
    logic poked;
    settle();
    first_done = done_seen;
    offer(1'b1, cmd, sv, 1'($urandom_range(1)), 1'b0, poked);
    if (cmd <= CMD_WRITE_STATUS) beats_counted++;
    // The longest sequence is a little over 200 microseconds plus the wait for
    // the sensor; the cap only keeps a broken block from running forever.
    cap   = 300 * tpu_now + 2000 + high_ticks;
    ticks = 0;
    while (cmd <= CMD_WRITE_STATUS && done_seen == first_done && ticks < cap) begin
      offer(1'b0, 3'($urandom_range(7)), 8'($urandom),
            (ticks < high_ticks) ? 1'b1 : ($urandom_range(99) < p_one), noise, poked);
      if (!poked) begin
        ticks++;
        beats_counted++;
      end
    end
  endtask

  initial begin : stimulus
    logic       poked;
    int         p_one;
    logic [2:0] cmd;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Ticks while idle change nothing. Then a connection reset at the reset rate.
    repeat (3) offer(1'b0, CMD_CONN_RESET, 8'h00, 1'b0, 1'b0, poked);
    run_sequence(CMD_CONN_RESET, 8'h00, 0, 0, 1'b0);

    // One tick per microsecond, the fastest setting. Every command but the connection
    // reset once, with a well-behaved sensor, a noisy one and one that never acknowledges.
    write_tpu(1);
    run_sequence(CMD_SOFT_RESET, 8'hff, 0, 0, 1'b1);
    // The receiver holds off during this measurement and the input backs up.
    hold_go++;
    run_sequence(CMD_MEASURE_TEMP, 8'h00, 50, 0, 1'b1);
    // Neither side idles during this read.
    calm = 1'b1;
    run_sequence(CMD_READ_STATUS, 8'h00, 100, 0, 1'b0);
    calm = 1'b0;
    run_sequence(CMD_WRITE_STATUS, 8'hc5, 0, 0, 1'b0);
    // Spare selectors leave the block idle.
    run_sequence(CmdSpare6, 8'h81, 0, 0, 1'b0);
    run_sequence(CmdSpare7, 8'h7e, 0, 0, 1'b0);
    // A sensor holding data high for the first ticks of a humidity measurement, all
    // before the acknowledge; the block ignores the starts that arrive while it is busy.
    run_sequence(CMD_MEASURE_HUM, 8'h5a, 50, 40, 1'b1);

    // Zero ticks per microsecond behaves as one.
    write_tpu(0);
    run_sequence(CMD_CONN_RESET, 8'ha5, 50, 0, 1'b0);

    // Random part: complete sequences with random commands, status bytes and
    // sensor behavior, stray starts while busy, spare selectors and idle ticks,
    // over a few fast prescaler settings.
    while (beats_counted < TargetBeats) begin
      if ($urandom_range(2) == 0) write_tpu(($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1);
      if ($urandom_range(4) == 0) begin
        offer(1'b1, ($urandom_range(1) == 0) ? CmdSpare6 : CmdSpare7, 8'($urandom),
              1'($urandom_range(1)), 1'b0, poked);
        repeat ($urandom_range(3)) begin
          offer(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)), 1'b0, poked);
        end
      end
      cmd = 3'($urandom_range(5));
      case ($urandom_range(4))
        0:       p_one = 0;
        1:       p_one = 5;
        2:       p_one = 50;
        3:       p_one = 85;
        default: p_one = 100;
      endcase
      // A measurement would wait forever on a data line that never goes low.
      if ((cmd == CMD_MEASURE_TEMP || cmd == CMD_MEASURE_HUM) && p_one == 100) p_one = 85;
      run_sequence(cmd, 8'($urandom), p_one, 0, 1'b1);
    end

    settle();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
